@@ src/scwc_pkg.sv @@
package scwc_pkg;

   localparam int POS_BITS_DEFAULT   = 16;
   localparam int DEPTH_BITS_DEFAULT = 8;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'd9;
   localparam logic [7:0] CHAR_VTAB     = 8'd11;
   localparam logic [7:0] CHAR_FEED     = 8'd12;
   localparam logic [7:0] CHAR_HIGH_MIN = 8'd128;
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;
   localparam logic [7:0] CHAR_STAR     = 8'h2A;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   typedef enum logic [1:0] {
      CLASS_SPACE       = 2'd0,
      CLASS_COMMENT     = 2'd1,
      CLASS_SIGNIFICANT = 2'd2,
      CLASS_NEWLINE     = 2'd3
   } byte_class_type;

   typedef enum logic [2:0] {
      MODE_CODE  = 3'b001,
      MODE_BLOCK = 3'b010,
      MODE_LINE  = 3'b100
   } scan_mode_type;

   typedef enum logic [1:0] {
      NL_NONE = 2'd0,
      NL_LF   = 2'd1,
      NL_CR   = 2'd2
   } newline_kind_type;

   function automatic logic is_newline(input logic [7:0] b);
      return (b == CHAR_LF) || (b == CHAR_CR);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= CHAR_HIGH_MIN) ||
             ((b >= 8'd1) && (b <= CHAR_TAB)) || (b == CHAR_VTAB) || (b == CHAR_FEED);
   endfunction

endpackage

@@ src/scwc_if.sv @@
interface scwc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface scwc_rsp_if #(parameter int POS_BITS = 16);
   logic                valid;
   logic                ready;
   logic [7:0]          out_byte;
   logic [1:0]          byte_class;
   logic [POS_BITS-1:0] line_number;
   logic [POS_BITS-1:0] column_number;
   logic                comment_open;
   logic                out_last;

   modport source (output valid, output out_byte, output byte_class, output line_number,
                   output column_number, output comment_open, output out_last, input ready);
   modport sink   (input valid, input out_byte, input byte_class, input line_number,
                   input column_number, input comment_open, input out_last, output ready);
endinterface

@@ src/scwc_scanner.sv @@
module scwc_scanner
   import scwc_pkg::*;
#(
   parameter int  POS_BITS   = POS_BITS_DEFAULT,
   parameter int  DEPTH_BITS = DEPTH_BITS_DEFAULT,
   parameter type rsp_type   = logic
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_value,
   input  logic       last_byte,
   output logic [1:0] push_count,
   output rsp_type    push_data [2]
);

   scan_mode_type         mode_ff,  mode_in;
   logic                  held_ff,  held_in;
   logic [POS_BITS-1:0]   held_col_ff, held_col_in;
   logic                  star_ff,  star_in;
   logic                  slash_ff, slash_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   newline_kind_type      kind_ff,  kind_in;
   logic [POS_BITS-1:0]   line_ff,  line_in;
   logic [POS_BITS-1:0]   col_ff,   col_in;

   logic                  nl;
   newline_kind_type      kind;
   logic [1:0]            n;
   logic [1:0]            code_class;
   logic [DEPTH_BITS-1:0] depth_dec;
   rsp_type               r0, r1;

   always_comb begin
      nl   = is_newline(byte_value);
      kind = (byte_value == CHAR_LF) ? NL_LF : NL_CR;
      if (nl) begin
         code_class = CLASS_NEWLINE;
      end else if (is_space(byte_value)) begin
         code_class = CLASS_SPACE;
      end else begin
         code_class = CLASS_SIGNIFICANT;
      end
      depth_dec = (depth_ff != '0) ? depth_ff - 1'b1 : depth_ff;

      mode_in     = mode_ff;
      held_in     = held_ff;
      held_col_in = held_col_ff;
      star_in     = star_ff;
      slash_in    = slash_ff;
      depth_in    = depth_ff;
      kind_in     = kind_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      n           = 2'd0;

      r0 = '0;
      r0.out_byte      = byte_value;
      r0.byte_class    = nl ? CLASS_NEWLINE : CLASS_COMMENT;
      r0.line_number   = line_ff;
      r0.column_number = col_ff;
      r1 = r0;

      if (nl) begin
         if ((kind_ff != NL_NONE) && (kind_ff != kind)) begin
            kind_in = NL_NONE;
         end else begin
            if (line_ff != '1) line_in = line_ff + 1'b1;
            col_in  = '0;
            kind_in = kind;
         end
      end else begin
         if (col_ff != '1) col_in = col_ff + 1'b1;
         kind_in = NL_NONE;
      end

      unique case (mode_ff)
         MODE_BLOCK: begin
            n = 2'd1;
            if (slash_ff && (byte_value == CHAR_STAR)) begin
               if (depth_ff != '1) depth_in = depth_ff + 1'b1;
               slash_in = 1'b0;
               star_in  = 1'b0;
            end else if (star_ff && (byte_value == CHAR_SLASH)) begin
               slash_in = 1'b0;
               star_in  = 1'b0;
               depth_in = depth_dec;
               if (depth_dec == '0) mode_in = MODE_CODE;
            end else begin
               slash_in = (byte_value == CHAR_SLASH);
               star_in  = (byte_value == CHAR_STAR);
            end
         end
         MODE_LINE: begin
            n = 2'd1;
            if (nl) mode_in = MODE_CODE;
         end
         MODE_CODE: begin
            if (held_ff) begin
               held_in = 1'b0;
               r0.out_byte      = CHAR_SLASH;
               r0.column_number = held_col_ff;
               if ((byte_value == CHAR_STAR) || (byte_value == CHAR_SLASH)) begin
                  r0.byte_class = CLASS_COMMENT;
                  r1.byte_class = CLASS_COMMENT;
                  n = 2'd2;
                  if (byte_value == CHAR_STAR) begin
                     mode_in  = MODE_BLOCK;
                     depth_in = DEPTH_BITS'(1);
                     star_in  = 1'b0;
                     slash_in = 1'b0;
                  end else begin
                     mode_in = MODE_LINE;
                  end
               end else begin
                  r0.byte_class = CLASS_SIGNIFICANT;
                  r1.byte_class = code_class;
                  n = 2'd2;
               end
            end else if ((byte_value == CHAR_SLASH) && !last_byte) begin
               held_in     = 1'b1;
               held_col_in = col_ff;
            end else begin
               r0.byte_class = code_class;
               n = 2'd1;
            end
         end
         default: begin
            mode_in = MODE_CODE;
         end
      endcase

      if (last_byte) begin
         if (n == 2'd2) begin
            r1.comment_open = (mode_in == MODE_BLOCK);
            r1.out_last     = 1'b1;
         end else begin
            r0.comment_open = (mode_in == MODE_BLOCK);
            r0.out_last     = 1'b1;
         end
         if (n != 2'd0) begin
            mode_in     = MODE_CODE;
            held_in     = 1'b0;
            held_col_in = '0;
            star_in     = 1'b0;
            slash_in    = 1'b0;
            depth_in    = '0;
            kind_in     = NL_NONE;
            line_in     = '0;
            col_in      = '0;
         end
      end
   end

   assign push_count   = accept ? n : 2'd0;
   assign push_data[0] = r0;
   assign push_data[1] = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_CODE;
         held_ff     <= 1'b0;
         held_col_ff <= '0;
         star_ff     <= 1'b0;
         slash_ff    <= 1'b0;
         depth_ff    <= '0;
         kind_ff     <= NL_NONE;
         line_ff     <= '0;
         col_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         held_ff     <= held_in;
         held_col_ff <= held_col_in;
         star_ff     <= star_in;
         slash_ff    <= slash_in;
         depth_ff    <= depth_in;
         kind_ff     <= kind_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
      end
   end

endmodule

@@ src/scwc_queue.sv @@
module scwc_queue
   import scwc_pkg::*;
#(
   parameter type elem_type = logic
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  elem_type   push_data [2],
   input  logic       pop,
   output logic       in_ready,
   output logic       out_valid,
   output elem_type   out_data
);

   localparam int DEPTH = 3;

   elem_type   entry_ff [DEPTH];
   elem_type   entry_in [DEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] base;

   always_comb begin
      base = (pop && (count_ff != 2'd0)) ? count_ff - 2'd1 : count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && (i < DEPTH - 1)) begin
            entry_in[i] = entry_ff[i + 1];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if ((push_count != 2'd0) && (base == 2'(i))) begin
            entry_in[i] = push_data[0];
         end
         if ((push_count == 2'd2) && ((base + 2'd1) == 2'(i))) begin
            entry_in[i] = push_data[1];
         end
      end
      count_in = base + push_count;
   end

   assign in_ready  = (count_ff <= 2'd1);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

@@ src/source_comment_whitespace_classifier_unit.sv @@
// Classifies source text one byte per request as whitespace, comment, significant or
// newline, with its zero-based line and column; block comments nest and a slash in code
// is held back one byte to see whether a comment starts. A request is taken every cycle
// while the three-entry result queue holds at most one result, so the block sustains one
// byte per cycle; a held slash released together with the next byte yields two results.
// Results are registered in the queue before they appear on the response bus.
module source_comment_whitespace_classifier_unit
   import scwc_pkg::*;
#(
   parameter int POS_BITS   = POS_BITS_DEFAULT,
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   scwc_req_if.sink             req_bus,
   scwc_rsp_if.source           rsp_bus
);

   typedef struct packed {
      logic [7:0]          out_byte;
      logic [1:0]          byte_class;
      logic [POS_BITS-1:0] line_number;
      logic [POS_BITS-1:0] column_number;
      logic                comment_open;
      logic                out_last;
   } rsp_type;

   logic       accept;
   logic       in_ready;
   logic [1:0] push_count;
   rsp_type    push_data [2];
   rsp_type    head;

   assign req_bus.ready = in_ready;
   assign accept        = req_bus.valid && in_ready;

   scwc_scanner #(
      .POS_BITS   (POS_BITS),
      .DEPTH_BITS (DEPTH_BITS),
      .rsp_type   (rsp_type)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_bus.byte_value),
      .last_byte  (req_bus.last_byte),
      .push_count (push_count),
      .push_data  (push_data)
   );

   scwc_queue #(
      .elem_type (rsp_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .pop        (rsp_bus.valid && rsp_bus.ready),
      .in_ready   (in_ready),
      .out_valid  (rsp_bus.valid),
      .out_data   (head)
   );

   assign rsp_bus.out_byte      = head.out_byte;
   assign rsp_bus.byte_class    = head.byte_class;
   assign rsp_bus.line_number   = head.line_number;
   assign rsp_bus.column_number = head.column_number;
   assign rsp_bus.comment_open  = head.comment_open;
   assign rsp_bus.out_last      = head.out_last;

endmodule
